[design/sgb_pkg.sv]
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types, codes and helpers of the separable gaussian blur core.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int COORD_W     = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_TAP_COUNT    = 3'd2,
        CFG_NEAR_COEF    = 3'd3,
        CFG_FAR_COEF     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       command;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [9:0] out_column;
        logic [9:0] out_row;
        logic       last_of_run;
        logic       frame_done;
    } pixel_out_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [3:0]  tap_count;
        logic [63:0] near_coef;
        logic [63:0] far_coef;
    } cfg_t;

    typedef enum logic {
        JOB_PIXEL,
        JOB_DRAIN
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic               bypass;
        logic               run_h;
        logic               run_v;
        logic               fd_last;
        logic [23:0]        pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] xfirst;
        logic [COORD_W-1:0] xlast;
        logic [COORD_W-1:0] hrow;
        logic [COORD_W-1:0] vrow;
        logic [COORD_W-1:0] rmax;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HTAP,
        BK_HSTORE,
        BK_VTAP,
        BK_EMIT
    } back_state_t;

    // kernel length limited to the build maximum
    function automatic logic [3:0] eff_taps(logic [3:0] tap_count, int max_taps);
        logic [3:0] k;
        k = (32'(tap_count) > max_taps) ? 4'(max_taps) : tap_count;
        return k;
    endfunction

    // rows and columns by which the output trails the input
    function automatic logic [3:0] tap_lag(logic [3:0] k);
        logic [3:0] r;
        r = (k == 4'd0) ? 4'd0 : (k - 4'd1 - {1'b0, k[3:1]});
        return r;
    endfunction

endpackage

[design/sgb_queue.sv]
// ----------------------------------------------------------------------------
// sgb_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module sgb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sgb_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output sgb_pkg::job_t job_out,
    output logic          empty
);

    sgb_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign job_out = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[design/sgb_front.sv]
// ----------------------------------------------------------------------------
// sgb_front
// Accepts words, tracks raster position and drain state, issues jobs.
// ----------------------------------------------------------------------------
module sgb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_TAPS   = 15
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sgb_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  sgb_pkg::pixel_in_t s_data,
    input  logic               q_full,
    output logic               q_push,
    output sgb_pkg::job_t      q_job
);

    localparam int CO = sgb_pkg::COORD_W;
    localparam int EW = CO + 2;

    logic [CO-1:0] col_reg, col_next;
    logic [CO-1:0] row_reg, row_next;
    logic          pend_active_reg, pend_active_next;
    logic [CO-1:0] pend_x_reg, pend_x_next;
    logic [CO-1:0] pend_y_reg, pend_y_next;
    logic [CO-1:0] pend_wl_reg, pend_wl_next;
    logic [CO-1:0] pend_last_reg, pend_last_next;

    logic [EW-1:0] w_cfg, h_cfg;
    logic [CO-1:0] wl, hl, c, r, lag_c, rows, h_total;
    logic [3:0]    k, lag;
    logic          accept, endrow, lastframe, bypass, drain_fd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        w_cfg = EW'(cfg.image_width);
        h_cfg = EW'(cfg.image_height);
        // last column and last row after clamping the sizes
        priority if (w_cfg == '0) wl = '0;
        else if (w_cfg > EW'(MAX_WIDTH)) wl = CO'(MAX_WIDTH - 1);
        else wl = CO'(w_cfg - EW'(1));
        priority if (h_cfg == '0) hl = '0;
        else if (h_cfg > EW'(MAX_HEIGHT)) hl = CO'(MAX_HEIGHT - 1);
        else hl = CO'(h_cfg - EW'(1));

        k       = sgb_pkg::eff_taps(cfg.tap_count, MAX_TAPS);
        lag     = sgb_pkg::tap_lag(k);
        lag_c   = CO'(lag);
        bypass  = (k <= 4'd1);
        c       = (col_reg > wl) ? wl : col_reg;
        r       = (row_reg > hl) ? hl : row_reg;
        endrow  = (c == wl);
        lastframe = endrow && (r == hl);
        h_total = hl + CO'(1);
        rows    = (lag_c < h_total) ? lag_c : h_total;
        drain_fd = (pend_y_reg == pend_last_reg) && (pend_x_reg == pend_wl_reg);

        col_next         = col_reg;
        row_next         = row_reg;
        pend_active_next = pend_active_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_wl_next     = pend_wl_reg;
        pend_last_next   = pend_last_reg;

        q_job = '0;
        if (s_data.command == sgb_pkg::CMD_DRAIN) begin
            q_job.kind    = sgb_pkg::JOB_DRAIN;
            q_job.run_v   = 1'b1;
            q_job.fd_last = drain_fd;
            q_job.xfirst  = pend_x_reg;
            q_job.xlast   = pend_x_reg;
            q_job.vrow    = pend_y_reg;
            q_job.rmax    = pend_last_reg;
            q_push        = accept && pend_active_reg;
            if (q_push) begin
                if (pend_x_reg == pend_wl_reg) begin
                    pend_x_next = '0;
                    pend_y_next = pend_y_reg + CO'(1);
                end else begin
                    pend_x_next = pend_x_reg + CO'(1);
                end
                if (drain_fd) begin
                    pend_active_next = 1'b0;
                end
            end
        end else begin
            q_job.kind   = sgb_pkg::JOB_PIXEL;
            q_job.bypass = bypass;
            q_job.pix    = {s_data.blue_in, s_data.green_in, s_data.red_in};
            q_job.col    = c;
            q_job.hrow   = r;
            q_job.rmax   = r;
            if (bypass) begin
                q_job.xfirst  = c;
                q_job.xlast   = c;
                q_job.vrow    = r;
                q_job.fd_last = lastframe;
            end else begin
                q_job.run_h   = endrow || (c >= lag_c);
                q_job.run_v   = (r >= lag_c);
                q_job.xfirst  = (c >= lag_c) ? (c - lag_c) : '0;
                q_job.xlast   = endrow ? c : (c - lag_c);
                q_job.vrow    = r - lag_c;
                q_job.fd_last = endrow && ((r - lag_c) == hl);
            end
            q_push = accept;
            if (accept) begin
                pend_active_next = lastframe && !bypass && (rows != '0);
                pend_x_next      = '0;
                pend_y_next      = h_total - rows;
                pend_wl_next     = wl;
                pend_last_next   = hl;
                if (endrow) begin
                    col_next = '0;
                    row_next = lastframe ? '0 : (r + CO'(1));
                end else begin
                    col_next = c + CO'(1);
                    row_next = r;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            pend_active_reg <= 1'b0;
        end else begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            pend_active_reg <= pend_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        pend_wl_reg   <= pend_wl_next;
        pend_last_reg <= pend_last_next;
    end

endmodule

[design/sgb_back.sv]
// ----------------------------------------------------------------------------
// sgb_back
// Runs jobs: row window, horizontal and vertical taps, line store, output.
// ----------------------------------------------------------------------------
module sgb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_TAPS  = 15,
    parameter int COEF_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sgb_pkg::cfg_t       cfg,
    input  logic                q_empty,
    output logic                q_pop,
    input  sgb_pkg::job_t       q_job,
    output logic                m_valid,
    input  logic                m_ready,
    output sgb_pkg::pixel_out_t m_data
);

    localparam int CO   = sgb_pkg::COORD_W;
    localparam int SB   = $clog2(MAX_TAPS + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int FRAC = COEF_BITS - 1;
    localparam int SHR  = (FRAC >= 8) ? FRAC - 8 : 0;
    localparam int SHL  = (FRAC < 8) ? 8 - FRAC : 0;
    localparam int AW   = COEF_BITS + 16 + 4;
    localparam int PW   = CO + 2;

    logic [23:0] win_mem [2**SB];
    logic [47:0] line_mem [2**(SB+CW)];
    logic [23:0] win_q_reg;
    logic [47:0] line_q_reg;

    sgb_pkg::back_state_t state_reg, state_next;
    sgb_pkg::job_t        job_reg, job_next;
    logic [CO-1:0]        x_reg, x_next;
    logic [3:0]           t_reg, t_next;
    logic [AW-1:0]        acc_reg [3];
    logic [AW-1:0]        acc_next [3];
    logic                 p1_reg, p1_next;
    logic [COEF_BITS-1:0] w_p1_reg, w_p1_next;
    logic                 m_valid_reg, m_valid_next;
    sgb_pkg::pixel_out_t  m_data_reg, m_data_next;

    logic [3:0]           k, d;
    logic [2:0]           half;
    logic signed [PW-1:0] pos_s, hi_s;
    logic [CO-1:0]        base, hi, pos_c;
    logic [63:0]          wword;
    logic [15:0]          wslot;
    logic                 issue, clear_acc, load_out, line_we, is_last;
    logic [47:0]          h_word;
    logic [23:0]          v_word, rgb;
    logic [AW:0]          h_tmp [3];
    logic [AW-1:0]        v_tmp [3];
    logic [15:0]          tap_data [3];
    logic [COEF_BITS+15:0] prod [3];

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // tap address and weight for tap t of the current phase
    always_comb begin
        k     = sgb_pkg::eff_taps(cfg.tap_count, MAX_TAPS);
        half  = k[3:1];
        base  = (state_reg == sgb_pkg::BK_HTAP) ? x_reg : job_reg.vrow;
        hi    = (state_reg == sgb_pkg::BK_HTAP) ? job_reg.col : job_reg.rmax;
        hi_s  = $signed({2'b00, hi});
        pos_s = $signed({2'b00, base}) + $signed(PW'(t_reg)) - $signed(PW'(half));
        priority if (pos_s < 0) pos_c = '0;
        else if (pos_s > hi_s) pos_c = hi;
        else pos_c = pos_s[CO-1:0];
        d     = (t_reg >= {1'b0, half}) ? (t_reg - {1'b0, half}) : ({1'b0, half} - t_reg);
        wword = d[2] ? cfg.far_coef : cfg.near_coef;
        wslot = wword[16*d[1:0] +: 16];
        issue = ((state_reg == sgb_pkg::BK_HTAP) || (state_reg == sgb_pkg::BK_VTAP))
                && (t_reg < k);
    end

    // shared multiply-accumulate and result formatting
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            tap_data[ch] = (state_reg == sgb_pkg::BK_HTAP) ? {8'd0, win_q_reg[8*ch +: 8]}
                                                           : line_q_reg[16*ch +: 16];
            prod[ch]     = w_p1_reg * tap_data[ch];
            h_tmp[ch]    = ((AW+1)'(acc_reg[ch]) >> SHR) << SHL;
            h_word[16*ch +: 16] = (h_tmp[ch] > (AW+1)'(16'hFFFF)) ? 16'hFFFF
                                                                  : h_tmp[ch][15:0];
            v_tmp[ch]    = acc_reg[ch] >> (8 + FRAC);
            v_word[8*ch +: 8] = (v_tmp[ch] > AW'(255)) ? 8'hFF : v_tmp[ch][7:0];
        end
        rgb     = job_reg.bypass ? job_reg.pix : v_word;
        is_last = (x_reg == job_reg.xlast);
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        x_next     = x_reg;
        t_next     = t_reg;
        q_pop      = 1'b0;
        clear_acc  = 1'b0;
        load_out   = 1'b0;
        line_we    = 1'b0;
        p1_next    = issue;
        w_p1_next  = wslot[COEF_BITS-1:0];

        unique case (state_reg)
            sgb_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    x_next    = q_job.xfirst;
                    t_next    = 4'd0;
                    clear_acc = 1'b1;
                    priority if (q_job.kind == sgb_pkg::JOB_DRAIN) state_next = sgb_pkg::BK_VTAP;
                    else if (q_job.bypass) state_next = sgb_pkg::BK_EMIT;
                    else if (q_job.run_h) state_next = sgb_pkg::BK_HTAP;
                    else state_next = sgb_pkg::BK_IDLE;
                end
            end
            sgb_pkg::BK_HTAP: begin
                if (issue) t_next = t_reg + 4'd1;
                else state_next = sgb_pkg::BK_HSTORE;
            end
            sgb_pkg::BK_HSTORE: begin
                line_we   = 1'b1;
                t_next    = 4'd0;
                clear_acc = 1'b1;
                priority if (job_reg.run_v) state_next = sgb_pkg::BK_VTAP;
                else if (is_last) state_next = sgb_pkg::BK_IDLE;
                else begin
                    x_next     = x_reg + CO'(1);
                    state_next = sgb_pkg::BK_HTAP;
                end
            end
            sgb_pkg::BK_VTAP: begin
                if (issue) t_next = t_reg + 4'd1;
                else state_next = sgb_pkg::BK_EMIT;
            end
            sgb_pkg::BK_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    if (is_last) begin
                        state_next = sgb_pkg::BK_IDLE;
                    end else begin
                        x_next     = x_reg + CO'(1);
                        t_next     = 4'd0;
                        clear_acc  = 1'b1;
                        state_next = sgb_pkg::BK_HTAP;
                    end
                end
            end
            default: state_next = sgb_pkg::BK_IDLE;
        endcase

        for (int ch = 0; ch < 3; ch++) begin
            if (clear_acc) acc_next[ch] = '0;
            else if (p1_reg) acc_next[ch] = acc_reg[ch] + AW'(prod[ch]);
            else acc_next[ch] = acc_reg[ch];
        end

        m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_data_next.red_out     = rgb[7:0];
            m_data_next.green_out   = rgb[15:8];
            m_data_next.blue_out    = rgb[23:16];
            m_data_next.out_column  = x_reg[9:0];
            m_data_next.out_row     = job_reg.vrow[9:0];
            m_data_next.last_of_run = is_last;
            m_data_next.frame_done  = job_reg.fd_last && is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sgb_pkg::BK_IDLE;
            p1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p1_reg      <= p1_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        x_reg      <= x_next;
        t_reg      <= t_next;
        w_p1_reg   <= w_p1_next;
        m_data_reg <= m_data_next;
        for (int ch = 0; ch < 3; ch++) begin
            acc_reg[ch] <= acc_next[ch];
        end
    end

    // row window, slot is column mod 2**SB
    always_ff @(posedge aclk) begin
        if (q_pop && (q_job.kind == sgb_pkg::JOB_PIXEL)) begin
            win_mem[q_job.col[SB-1:0]] <= q_job.pix;
        end
        win_q_reg <= win_mem[pos_c[SB-1:0]];
    end

    // line store of filtered rows, row slot in the upper address bits
    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_mem[{job_reg.hrow[SB-1:0], x_reg[CW-1:0]}] <= h_word;
        end
        line_q_reg <= line_mem[{pos_c[SB-1:0], x_reg[CW-1:0]}];
    end

endmodule

[design/separable_gaussian_blur_rgb_core.sv]
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb_core
// Separable gaussian blur of a raster RGB stream with clamp to the edge.
// ----------------------------------------------------------------------------
// usage
//   s_*   : input words, command 0 = pixel, 1 = drain step
//   m_*   : blurred pixels with column, row, last_of_run and frame_done
//   cfg_* : register writes (width, height, tap count, weights), always ready
//   a pixel word is taken into a two-entry job queue while it is not full;
//   the back end then works on one job at a time
//   per output column the shared tap unit runs the row filter, writes the
//   line store, runs the column filter and loads the output register, one
//   result at a time, limited by the single multiply-accumulate unit and
//   the one read port of each store; a pixel word that completes no column
//   only passes through the idle state, and a bypass word (k <= 1) goes
//   straight to the output register
//   results follow their pixel by the kernel lag in rows and columns;
//   drain words flush the bottom rows of a frame, one result each
//   reset clears positions, drain state, the queue and the output register;
//   the stores start unwritten and need no clearing pass
//   a stalled receiver holds the output register; the back end waits and
//   the queue keeps taking words until it is full
// ----------------------------------------------------------------------------
module separable_gaussian_blur_rgb_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_TAPS   = 15,
    parameter int COEF_BITS  = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sgb_pkg::pixel_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sgb_pkg::pixel_out_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sgb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    sgb_pkg::cfg_t cfg_reg, cfg_next;

    // job queue between front and back
    logic          q_push, q_full, q_pop, q_empty;
    sgb_pkg::job_t q_job_in, q_job_out;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sgb_pkg::CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[10:0];
                sgb_pkg::CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[10:0];
                sgb_pkg::CFG_TAP_COUNT:    cfg_next.tap_count    = cfg_data[3:0];
                sgb_pkg::CFG_NEAR_COEF:    cfg_next.near_coef    = cfg_data;
                sgb_pkg::CFG_FAR_COEF:     cfg_next.far_coef     = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= 11'd1024;
            cfg_reg.image_height <= 11'd1024;
            cfg_reg.tap_count    <= 4'd1;
            cfg_reg.near_coef    <= 64'd0;
            cfg_reg.far_coef     <= 64'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: position tracking, drain bookkeeping, job classification
    sgb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_TAPS   (MAX_TAPS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_job_in)
    );

    sgb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .job_in  (q_job_in),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (q_job_out),
        .empty   (q_empty)
    );

    // back: filter taps, line store and output register
    sgb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS),
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_job   (q_job_out),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("job queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty))
        else $error("job queue underflow");

    // frame end only on the last result of a run
    a_fd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> m_data.last_of_run)
        else $error("frame_done without last_of_run");

    // output register empty right after reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
